// ===== src/irqown_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irqown_pkg
// Shared types and codes for the interrupt ownership and wait table.
// ----------------------------------------------------------------------------
package irqown_pkg;

  // request modes
  localparam logic [2:0] MODE_START    = 3'd0;
  localparam logic [2:0] MODE_STOP     = 3'd1;
  localparam logic [2:0] MODE_WAIT     = 3'd2;
  localparam logic [2:0] MODE_COMPLETE = 3'd3;
  localparam logic [2:0] MODE_ENABLE   = 3'd4;
  localparam logic [2:0] MODE_DISABLE  = 3'd5;
  localparam logic [2:0] MODE_HW_IRQ   = 3'd6;
  localparam logic [2:0] MODE_UNKNOWN  = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNAUTH  = 2'd1;
  localparam logic [1:0] ST_PARAM   = 2'd2;
  localparam logic [1:0] ST_STARTED = 2'd3;

  // interrupt controller actions
  localparam logic [1:0] PIC_NONE   = 2'd0;
  localparam logic [1:0] PIC_EOI    = 2'd1;
  localparam logic [1:0] PIC_MASK   = 2'd2;
  localparam logic [1:0] PIC_UNMASK = 2'd3;

  // lines that can never be monitored
  localparam logic [7:0] IRQ_TIMER   = 8'd0;
  localparam logic [7:0] IRQ_CASCADE = 8'd2;
  localparam logic [7:0] IRQ_RTC     = 8'd8;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] task_id;
    logic        is_driver;
    logic [7:0]  irq_number;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  pic_action;
    logic [3:0]  pic_irq;
    logic        caller_blocks;
    logic        wake_valid;
    logic [15:0] wake_task_id;
    logic [15:0] pending_mask;
  } out_t;

  // work classes handed from the front to the back
  typedef enum logic [2:0] {
    OP_DONE,   // answer already known, no table access
    OP_HW,
    OP_START,
    OP_STOP,
    OP_WAIT,
    OP_CTRL
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  status;
    logic [1:0]  act;
    logic [15:0] task_id;
    logic [7:0]  irq_number;
  } qent_t;

endpackage

// ===== src/irqown_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irqown_front
// Accepts requests and classifies them; argument checks that need no table
// access are answered here and passed on as finished work.
// ----------------------------------------------------------------------------
module irqown_front import irqown_pkg::*; #(
  parameter int IRQ_COUNT = 16
) (
  input  logic  start,
  input  in_t   req,
  input  logic  q_full,
  output logic  busy,
  output logic  push,
  output qent_t entry
);

  logic irq_ok;
  logic reserved;

  assign busy   = q_full;
  assign push   = start && !q_full;
  assign irq_ok = 32'(req.irq_number) < IRQ_COUNT;

  always_comb begin
    reserved = !irq_ok;
    if (req.irq_number inside {IRQ_TIMER, IRQ_CASCADE, IRQ_RTC}) begin
      reserved = 1'b1;
    end
  end

  always_comb begin
    entry            = '0;
    entry.op         = OP_DONE;
    entry.status     = ST_OK;
    entry.act        = PIC_NONE;
    entry.task_id    = req.task_id;
    entry.irq_number = req.irq_number;
    if (req.mode == MODE_HW_IRQ) begin
      // lines out of range are dropped silently
      if (irq_ok) entry.op = OP_HW;
    end else if (!req.is_driver) begin
      entry.status = ST_UNAUTH;
    end else begin
      case (req.mode)
        MODE_START: begin
          if (reserved) entry.status = ST_PARAM;
          else          entry.op     = OP_START;
        end
        MODE_STOP: begin
          if (reserved) entry.status = ST_PARAM;
          else          entry.op     = OP_STOP;
        end
        MODE_WAIT: begin
          entry.op = OP_WAIT;
        end
        MODE_COMPLETE, MODE_ENABLE, MODE_DISABLE: begin
          if (!irq_ok) begin
            entry.status = ST_UNAUTH;
          end else begin
            entry.op = OP_CTRL;
            if (req.mode == MODE_COMPLETE)    entry.act = PIC_EOI;
            else if (req.mode == MODE_ENABLE) entry.act = PIC_UNMASK;
            else                              entry.act = PIC_MASK;
          end
        end
        default: begin
          entry.status = ST_PARAM;
        end
      endcase
    end
  end

endmodule

// ===== src/irqown_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irqown_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module irqown_queue import irqown_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_data,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output qent_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qent_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== src/irqown_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irqown_back
// Ownership table and its sequencer: line lookup, one-entry-per-cycle task
// search, then a single read-modify-write of the selected entry.
// ----------------------------------------------------------------------------
module irqown_back import irqown_pkg::*; #(
  parameter int IRQ_COUNT    = 16,
  parameter int TASK_ID_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        q_valid,
  input  qent_t       q_head,
  output logic        pop,
  output logic        done,
  output out_t        res
);

  localparam int EW = $clog2(IRQ_COUNT);
  localparam int TW = (TASK_ID_BITS < 16) ? TASK_ID_BITS : 16;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_SCAN = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t              state;
  qent_t               cur;
  logic [EW-1:0]       idx;
  logic [EW-1:0]       free_idx;
  logic                free_ok;
  logic [TW-1:0]       null_id;

  logic [IRQ_COUNT-1:0] owned;
  logic [EW-1:0]        owner_ent [IRQ_COUNT];
  logic [TW-1:0]        etask     [IRQ_COUNT];
  logic [IRQ_COUNT-1:0] emon      [IRQ_COUNT];
  logic [IRQ_COUNT-1:0] epend     [IRQ_COUNT];
  logic [IRQ_COUNT-1:0] ewait;

  logic [EW-1:0]        irq_i;
  logic [TW-1:0]        tk;
  logic [IRQ_COUNT-1:0] bit_mask;
  logic [TW-1:0]        t_rd;
  logic [IRQ_COUNT-1:0] mon_rd;
  logic [IRQ_COUNT-1:0] pend_rd;
  logic [IRQ_COUNT-1:0] pend_or;
  logic [IRQ_COUNT-1:0] mon_clr;
  logic [31:0]          pend_rd32;
  logic [31:0]          pend_or32;
  logic                 hit;
  logic                 is_free;
  logic                 last;
  logic                 nf_ok;
  logic [EW-1:0]        nf_idx;

  assign irq_i     = cur.irq_number[EW-1:0];
  assign tk        = cur.task_id[TW-1:0];
  assign bit_mask  = {{(IRQ_COUNT-1){1'b0}}, 1'b1} << irq_i;
  assign t_rd      = etask[idx];
  assign mon_rd    = emon[idx];
  assign pend_rd   = epend[idx];
  assign pend_or   = pend_rd | bit_mask;
  assign mon_clr   = mon_rd & ~bit_mask;
  assign pend_rd32 = 32'(pend_rd);
  assign pend_or32 = 32'(pend_or);
  assign hit       = t_rd == tk;
  assign is_free   = t_rd == null_id;
  assign last      = idx == EW'(IRQ_COUNT - 1);
  // allocation takes the highest-numbered free entry seen
  assign nf_ok     = free_ok || is_free;
  assign nf_idx    = is_free ? idx : free_idx;
  assign pop       = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) null_id <= '0;
    else if (cfg_we) null_id <= cfg_data[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      idx      <= '0;
      free_idx <= '0;
      free_ok  <= 1'b0;
      owned    <= '0;
      ewait    <= '0;
      for (int i = 0; i < IRQ_COUNT; i++) begin
        owner_ent[i] <= '0;
        etask[i]     <= '0;
        emon[i]      <= '0;
        epend[i]     <= '0;
      end
    end else begin
      done <= 1'b0;
      res  <= '0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur      <= q_head;
            idx      <= '0;
            free_ok  <= 1'b0;
            free_idx <= '0;
            if (q_head.op == OP_DONE) begin
              done       <= 1'b1;
              res.status <= q_head.status;
            end else if (q_head.op == OP_WAIT) begin
              state <= S_SCAN;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (owned[irq_i]) begin
            if (cur.op == OP_START) begin
              done       <= 1'b1;
              res.status <= ST_STARTED;
              state      <= S_IDLE;
            end else begin
              idx   <= owner_ent[irq_i];
              state <= S_EXEC;
            end
          end else if (cur.op == OP_START) begin
            state <= S_SCAN;
          end else begin
            // unowned line: raised irq is dropped, requests are refused
            done       <= 1'b1;
            res.status <= (cur.op == OP_HW) ? ST_OK : ST_UNAUTH;
            state      <= S_IDLE;
          end
        end
        S_SCAN: begin
          free_ok  <= nf_ok;
          free_idx <= nf_idx;
          if (hit) begin
            state <= S_EXEC;
          end else if (last) begin
            if (cur.op == OP_START && nf_ok) begin
              idx   <= nf_idx;
              state <= S_EXEC;
            end else begin
              done       <= 1'b1;
              res.status <= (cur.op == OP_START) ? ST_PARAM : ST_UNAUTH;
              state      <= S_IDLE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EXEC: begin
          done  <= 1'b1;
          state <= S_IDLE;
          case (cur.op)
            OP_HW: begin
              if (ewait[idx]) begin
                res.wake_valid   <= 1'b1;
                res.wake_task_id <= 16'(t_rd);
                res.pending_mask <= pend_or32[15:0];
                epend[idx]       <= '0;
                ewait[idx]       <= 1'b0;
              end else begin
                epend[idx] <= pend_or;
              end
            end
            OP_START: begin
              owned[irq_i]     <= 1'b1;
              owner_ent[irq_i] <= idx;
              emon[idx]        <= mon_rd | bit_mask;
              etask[idx]       <= tk;
            end
            OP_STOP: begin
              if (!hit) begin
                res.status <= ST_UNAUTH;
              end else begin
                emon[idx]    <= mon_clr;
                epend[idx]   <= pend_rd & ~bit_mask;
                owned[irq_i] <= 1'b0;
                if (mon_clr == '0) etask[idx] <= null_id;
              end
            end
            OP_WAIT: begin
              if (pend_rd == '0) begin
                ewait[idx]        <= 1'b1;
                res.caller_blocks <= 1'b1;
              end else begin
                res.pending_mask <= pend_rd32[15:0];
                epend[idx]       <= '0;
                ewait[idx]       <= 1'b0;
              end
            end
            OP_CTRL: begin
              if (!hit) begin
                res.status <= ST_UNAUTH;
              end else begin
                res.pic_action <= cur.act;
                res.pic_irq    <= cur.irq_number[3:0];
              end
            end
            default: begin
              res.status <= cur.status;
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) != S_IDLE) || $past(pop))
    else $error("result strobe without work in progress");

  a_exec_answers: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> done)
    else $error("entry update finished without a result");

  a_wake_clean: assert property (@(posedge clk) disable iff (rst)
    done && res.wake_valid |-> (res.status == ST_OK) && !res.caller_blocks)
    else $error("wake result carries a failure or a block");

  a_pic_ok: assert property (@(posedge clk) disable iff (rst)
    done && (res.pic_action != PIC_NONE) |-> (res.status == ST_OK) && !res.wake_valid)
    else $error("controller action on a refused request");

endmodule

// ===== src/irq_ownership_wait_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_ownership_wait_table
// Routes interrupt lines to registered driver tasks; handles start/stop
// monitoring, wait, complete/enable/disable and raised hardware lines.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy rises only
// when the two-entry request queue is full. Every request gives exactly one
// result, shown for a single cycle with done high, and results cannot be
// held off. Requests rejected on their arguments pass through the queue
// and are answered without table access. Line-based requests take a line
// lookup and an entry update. Wait searches the task table one entry per
// cycle; a start on a free line does the line lookup before the same
// search. The back end works on one request at a time and takes the next
// from the queue once it answers, so that search bounds the request rate.
// ----------------------------------------------------------------------------
module irq_ownership_wait_table import irqown_pkg::*; #(
  parameter int IRQ_COUNT    = 16,
  parameter int TASK_ID_BITS = 16,
  parameter int QUEUE_DEPTH  = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        start,
  input  in_t         req,
  output logic        busy,
  output logic        done,
  output out_t        res
);

  logic  q_full;
  logic  q_valid;
  logic  push;
  logic  pop;
  qent_t entry;
  qent_t head;

  irqown_front #(
    .IRQ_COUNT (IRQ_COUNT)
  ) u_front (
    .start  (start),
    .req    (req),
    .q_full (q_full),
    .busy   (busy),
    .push   (push),
    .entry  (entry)
  );

  irqown_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  irqown_back #(
    .IRQ_COUNT    (IRQ_COUNT),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_head   (head),
    .pop      (pop),
    .done     (done),
    .res      (res)
  );

endmodule

// ===== tb/irq_ownership_wait_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_ownership_wait_table_checker
// Watches the request, result and configuration ports of the IRQ ownership
// table, keeps its own copy of the table, and checks every result against the
// answer predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module irq_ownership_wait_table_checker import irqown_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        start,
  input  logic        busy,
  input  in_t         req,
  input  logic        done,
  input  out_t        res,
  output int          errors,
  output int          outstanding
);

  localparam int LINES   = 16;
  localparam int NO_SLOT = LINES;

  logic [15:0] null_id;
  logic [4:0]  line_owner   [LINES];
  logic [15:0] slot_task    [LINES];
  logic [15:0] slot_monitor [LINES];
  logic [15:0] slot_pending [LINES];
  logic        slot_waiting [LINES];

  out_t expected_answers[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic logic reserved_line(logic [7:0] line);
    return line >= LINES || line == IRQ_TIMER || line == IRQ_CASCADE || line == IRQ_RTC;
  endfunction

  // slot that tid holds line through, or NO_SLOT
  function automatic int owning_slot(logic [15:0] tid, logic [3:0] line);
    int s;
    s = line_owner[line];
    if (s == NO_SLOT) return NO_SLOT;
    if (slot_task[s] != tid) return NO_SLOT;
    return s;
  endfunction

  function automatic out_t predict_answer(in_t r);
    out_t        o;
    logic [15:0] line_bit;
    logic [3:0]  ln;
    int          s;
    int          hit;
    int          spare;
    o        = '0;
    line_bit = '0;
    ln       = r.irq_number[3:0];
    if (r.irq_number < LINES) line_bit = 16'h1 << ln;

    if (r.mode == MODE_HW_IRQ) begin
      if (r.irq_number < LINES && line_owner[ln] != NO_SLOT) begin
        s = line_owner[ln];
        slot_pending[s] |= line_bit;
        if (slot_waiting[s]) begin
          o.wake_valid    = 1'b1;
          o.wake_task_id  = slot_task[s];
          o.pending_mask  = slot_pending[s];
          slot_pending[s] = '0;
          slot_waiting[s] = 1'b0;
        end
      end
    end else if (!r.is_driver) begin
      o.status = ST_UNAUTH;
    end else begin
      case (r.mode)
        MODE_START: begin
          if (reserved_line(r.irq_number)) begin
            o.status = ST_PARAM;
          end else if (line_owner[ln] != NO_SLOT) begin
            o.status = ST_STARTED;
          end else begin
            // existing slot of the task wins; otherwise take the last free one
            hit   = NO_SLOT;
            spare = NO_SLOT;
            for (int i = 0; i < LINES; i++) begin
              if (hit == NO_SLOT && slot_task[i] == r.task_id) hit = i;
              if (slot_task[i] == null_id) spare = i;
            end
            if (hit == NO_SLOT && spare != NO_SLOT) begin
              slot_task[spare] = r.task_id;
              hit = spare;
            end
            if (hit == NO_SLOT) begin
              o.status = ST_PARAM;
            end else begin
              line_owner[ln]     = hit[4:0];
              slot_monitor[hit] |= line_bit;
            end
          end
        end
        MODE_STOP: begin
          if (reserved_line(r.irq_number)) begin
            o.status = ST_PARAM;
          end else begin
            s = owning_slot(r.task_id, ln);
            if (s == NO_SLOT) begin
              o.status = ST_UNAUTH;
            end else begin
              slot_monitor[s] &= ~line_bit;
              slot_pending[s] &= ~line_bit;
              if (slot_monitor[s] == '0) slot_task[s] = null_id;
              line_owner[ln] = NO_SLOT;
            end
          end
        end
        MODE_WAIT: begin
          hit = NO_SLOT;
          for (int i = LINES - 1; i >= 0; i--)
            if (slot_task[i] == r.task_id) hit = i;
          if (hit == NO_SLOT) begin
            o.status = ST_UNAUTH;
          end else if (slot_pending[hit] == '0) begin
            slot_waiting[hit] = 1'b1;
            o.caller_blocks   = 1'b1;
          end else begin
            o.pending_mask    = slot_pending[hit];
            slot_pending[hit] = '0;
            slot_waiting[hit] = 1'b0;
          end
        end
        MODE_COMPLETE, MODE_ENABLE, MODE_DISABLE: begin
          if (r.irq_number >= LINES || owning_slot(r.task_id, ln) == NO_SLOT) begin
            o.status = ST_UNAUTH;
          end else begin
            o.pic_action = (r.mode == MODE_COMPLETE) ? PIC_EOI :
                           (r.mode == MODE_ENABLE) ? PIC_UNMASK : PIC_MASK;
            o.pic_irq    = ln;
          end
        end
        default: begin
          o.status = ST_PARAM;
        end
      endcase
    end
    return o;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      null_id = '0;
      for (int i = 0; i < LINES; i++) begin
        line_owner[i]   = NO_SLOT;
        slot_task[i]    = '0;
        slot_monitor[i] = '0;
        slot_pending[i] = '0;
        slot_waiting[i] = 1'b0;
      end
      expected_answers.delete();
    end else begin
      if (done) begin
        if (expected_answers.size() == 0) begin
          if (errors < 10)
            $display("%t: unexpected result status=%0d pic=%0d/%0d blk=%0d wake=%0d/%h mask=%h",
                     $realtime, res.status, res.pic_action, res.pic_irq, res.caller_blocks,
                     res.wake_valid, res.wake_task_id, res.pending_mask);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (res.status !== want.status || res.pic_action !== want.pic_action ||
              res.pic_irq !== want.pic_irq || res.caller_blocks !== want.caller_blocks ||
              res.wake_valid !== want.wake_valid || res.wake_task_id !== want.wake_task_id ||
              res.pending_mask !== want.pending_mask) begin
            if (errors < 10) begin
              $display("%t: mismatch expected status=%0d pic=%0d/%0d blk=%0d wake=%0d/%h mask=%h",
                       $realtime, want.status, want.pic_action, want.pic_irq,
                       want.caller_blocks, want.wake_valid, want.wake_task_id,
                       want.pending_mask);
              $display("%t:          actual   status=%0d pic=%0d/%0d blk=%0d wake=%0d/%h mask=%h",
                       $realtime, res.status, res.pic_action, res.pic_irq, res.caller_blocks,
                       res.wake_valid, res.wake_task_id, res.pending_mask);
            end
            errors++;
          end
        end
      end
      if (cfg_we) null_id = cfg_data;
      if (start && !busy) expected_answers.push_back(predict_answer(req));
    end
    outstanding <= expected_answers.size();
  end

endmodule

// ===== tb/irq_ownership_wait_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_ownership_wait_table_test
// Drives directed and random ownership, wait, controller and hardware IRQ requests into
// the table across several free-entry id settings; the checker scores them.
// ----------------------------------------------------------------------------
module irq_ownership_wait_table_test;
  import irqown_pkg::*;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        cfg_we   = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        start    = 1'b0;
  in_t         req      = '0;
  logic        busy;
  logic        done;
  out_t        res;
  int          errors;
  int          outstanding;

  logic [15:0] null_now = '0;
  logic        calm     = 1'b0;
  int          sent     = 0;

  irq_ownership_wait_table uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .done     (done),
    .res      (res)
  );

  irq_ownership_wait_table_checker table_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .res         (res),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("irq_ownership_wait_table_test failed");
    $finish;
  end

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic issue(logic [2:0] m, logic [15:0] tid, logic drv, logic [7:0] line);
    in_t r;
    r.mode       = m;
    r.task_id    = tid;
    r.is_driver  = drv;
    r.irq_number = line;
    if (!calm && $urandom_range(0, 99) < 25) pause($urandom_range(1, 8));
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  // one edge first so that a request taken at the last edge is counted
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_null_id(logic [15:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    null_now = v;
  endtask

  // small task pool so lines get owned, waited on and raised repeatedly
  function automatic logic [15:0] pick_task();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return 16'd1 + 16'($urandom_range(0, 5));
    if (p < 87) return null_now;
    if (p < 93) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic run_random(int count);
    logic [2:0] m;
    logic [7:0] line;
    int         p;
    repeat (count) begin
      p = $urandom_range(0, 99);
      m = (p < 22) ? MODE_START :
          (p < 32) ? MODE_STOP :
          (p < 47) ? MODE_WAIT :
          (p < 52) ? MODE_COMPLETE :
          (p < 57) ? MODE_ENABLE :
          (p < 62) ? MODE_DISABLE :
          (p < 96) ? MODE_HW_IRQ : MODE_UNKNOWN;
      line = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15))
                                          : 8'($urandom_range(0, 255));
      calm = (sent >= 250 && sent < 400);
      issue(m, pick_task(), ($urandom_range(0, 99) < 92), line);
      sent++;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_null_id(16'h0000);

    // ownership and rejection paths
    issue(MODE_START, 16'd1, 1'b1, 8'd1);
    issue(MODE_START, 16'd2, 1'b1, 8'd1);
    issue(MODE_START, 16'd1, 1'b1, IRQ_TIMER);
    issue(MODE_START, 16'd1, 1'b1, IRQ_CASCADE);
    issue(MODE_START, 16'd1, 1'b1, IRQ_RTC);
    issue(MODE_START, 16'd1, 1'b1, 8'd255);
    issue(MODE_START, 16'd1, 1'b0, 8'd3);
    issue(MODE_UNKNOWN, 16'd1, 1'b1, 8'd1);
    issue(MODE_UNKNOWN, 16'd1, 1'b0, 8'd1);
    // blocking wait woken by the line, then a wait that finds it pending
    issue(MODE_WAIT, 16'd1, 1'b1, 8'd0);
    issue(MODE_HW_IRQ, 16'd0, 1'b0, 8'd1);
    issue(MODE_HW_IRQ, 16'd0, 1'b0, 8'd1);
    issue(MODE_WAIT, 16'd1, 1'b1, 8'd0);
    issue(MODE_COMPLETE, 16'd1, 1'b1, 8'd1);
    issue(MODE_ENABLE, 16'd1, 1'b1, 8'd1);
    issue(MODE_DISABLE, 16'd1, 1'b1, 8'd1);
    issue(MODE_COMPLETE, 16'd1, 1'b1, 8'd16);
    issue(MODE_COMPLETE, 16'd2, 1'b1, 8'd1);
    issue(MODE_ENABLE, 16'd1, 1'b1, 8'd3);
    issue(MODE_HW_IRQ, 16'hFFFF, 1'b1, 8'd200);
    issue(MODE_HW_IRQ, 16'd0, 1'b0, 8'd5);
    // task id equal to the free marker matches a free entry
    issue(MODE_WAIT, 16'd0, 1'b1, 8'd0);
    issue(MODE_WAIT, 16'd9, 1'b1, 8'd0);
    issue(MODE_STOP, 16'd2, 1'b1, 8'd1);
    issue(MODE_STOP, 16'd1, 1'b1, IRQ_CASCADE);
    issue(MODE_STOP, 16'd1, 1'b1, 8'd1);
    issue(MODE_START, 16'hFFFF, 1'b1, 8'd15);
    issue(MODE_HW_IRQ, 16'd0, 1'b0, 8'd15);

    run_random(200);
    write_null_id(16'hFFFF);
    run_random(170);
    write_null_id(16'($urandom));
    run_random(170);
    write_null_id(16'h0003);
    run_random(160);

    drain();
    if (errors == 0) begin
      $display("irq_ownership_wait_table_test passed");
    end else begin
      $display("irq_ownership_wait_table_test failed");
    end
    $finish;
  end

endmodule

// ===== irq_ownership_wait_table.f =====
src/irqown_pkg.sv
src/irqown_front.sv
src/irqown_queue.sv
src/irqown_back.sv
src/irq_ownership_wait_table.sv
tb/irq_ownership_wait_table_checker.sv
tb/irq_ownership_wait_table_test.sv
